// ===== rtl/kwmh_pkg.sv =====
// kwmh_pkg: shared types, codes and the heap ordering function for the
// k-way merge heap. No dependencies; used by kwmh_ctrl, kwmh_dp and the top.
package kwmh_pkg;

  localparam int MAX_STREAMS = 16;
  localparam int IDX_W       = 4;          // heap slot index
  localparam int CNT_W       = 5;          // heap fill count, 0..MAX_STREAMS
  localparam int CH_W        = IDX_W + 2;  // child index before range check
  localparam int KEY_W       = 32;

  // input command codes
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_TAKE   = 2'd2;
  localparam logic [1:0] CMD_REFILL = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ACK   = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_IDLE    = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_CLEAR   = 4'd2;
  localparam logic [3:0] OP_DONE    = 4'd3;
  localparam logic [3:0] OP_REJECT  = 4'd4;
  localparam logic [3:0] OP_INSERT  = 4'd5;
  localparam logic [3:0] OP_PUT     = 4'd6;
  localparam logic [3:0] OP_UP_RD   = 4'd7;
  localparam logic [3:0] OP_UP_MV   = 4'd8;
  localparam logic [3:0] OP_EXT_RD  = 4'd9;
  localparam logic [3:0] OP_EXTRACT = 4'd10;
  localparam logic [3:0] OP_DN_RD   = 4'd11;
  localparam logic [3:0] OP_DN_MV   = 4'd12;
  localparam logic [3:0] OP_OUT_LD  = 4'd13;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        src;
  } ent_t;

  typedef struct packed {
    logic [3:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;       // latched command of the word in work
    logic       ins_ok;    // present, source in range, room in heap
    logic       empty;     // heap count is zero
    logic       at_root;   // sift index is slot 0
    logic       up_move;   // moving entry orders before its parent
    logic       dn_move;   // a child orders before the moving entry
    logic       last_one;  // heap holds exactly one entry
    logic       out_busy;  // result register full and not drained
  } dp_sts_t;

  // a orders before b: signed key, ties to the lower source
  function automatic logic ent_before(input ent_t a, input ent_t b);
    if (a.key != b.key) return a.key < b.key;
    return a.src < b.src;
  endfunction

endpackage

// ===== rtl/kwmh_ctrl.sv =====
// kwmh_ctrl: sequencer for the merge heap; issues one datapath op per cycle.
// Depends on kwmh_pkg.
module kwmh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kwmh_pkg::dp_sts_t   sts,
  output kwmh_pkg::ctl_cmd_t  ctl
);
  import kwmh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_UPC  = 3'd3;
  localparam logic [2:0] S_EXT  = 3'd4;
  localparam logic [2:0] S_DN   = 3'd5;
  localparam logic [2:0] S_DNC  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.cmd)
          CMD_START: begin
            ctl.op    = OP_CLEAR;
            state_nxt = S_FIN;
          end
          CMD_TAKE: begin
            if (sts.empty) begin
              ctl.op    = OP_DONE;
              state_nxt = S_FIN;
            end else begin
              ctl.op    = OP_EXT_RD;
              state_nxt = S_EXT;
            end
          end
          default: begin  // load and refill
            if (sts.ins_ok) begin
              ctl.op    = OP_INSERT;
              state_nxt = S_UP;
            end else begin
              ctl.op    = OP_REJECT;
              state_nxt = S_FIN;
            end
          end
        endcase
      end
      S_UP: begin
        if (sts.at_root) begin
          ctl.op    = OP_PUT;
          state_nxt = S_FIN;
        end else begin
          ctl.op    = OP_UP_RD;
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        if (sts.up_move) begin
          ctl.op    = OP_UP_MV;
          state_nxt = S_UP;
        end else begin
          ctl.op    = OP_PUT;
          state_nxt = S_FIN;
        end
      end
      S_EXT: begin
        ctl.op    = OP_EXTRACT;
        state_nxt = sts.last_one ? S_FIN : S_DN;
      end
      S_DN: begin
        ctl.op    = OP_DN_RD;
        state_nxt = S_DNC;
      end
      S_DNC: begin
        if (sts.dn_move) begin
          ctl.op    = OP_DN_MV;
          state_nxt = S_DN;
        end else begin
          ctl.op    = OP_PUT;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.op    = OP_OUT_LD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/kwmh_dp.sv =====
// kwmh_dp: heap memory, sift registers, arity register and result register.
// Depends on kwmh_pkg; driven by kwmh_ctrl ops.
module kwmh_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kwmh_pkg::ctl_cmd_t           ctl,
  output kwmh_pkg::dp_sts_t            sts,
  input  logic [1:0]                   in_cmd,
  input  logic [kwmh_pkg::IDX_W-1:0]   in_source,
  input  logic signed [31:0]           in_value,
  input  logic                         in_present,
  input  logic                         cfg_we,
  input  logic [kwmh_pkg::CNT_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic signed [31:0]           out_value,
  output logic [kwmh_pkg::IDX_W-1:0]   out_taken_source,
  output logic                         out_taken_valid
);
  import kwmh_pkg::*;

  // heap storage, no reset
  ent_t mem [MAX_STREAMS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra, mem_rb;
  ent_t             mem_wd;
  ent_t             rda_r, rdb_r;

  logic [CNT_W-1:0] arity_cfg_r, arity;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  ent_t             cur_r, cur_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic             pres_r, pres_nxt;

  logic [1:0]        res_st_r, res_st_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic [IDX_W-1:0]  res_src_r, res_src_nxt;
  logic              res_tv_r, res_tv_nxt;

  logic              out_valid_r;
  logic [1:0]        out_st_r;
  logic signed [31:0] out_val_r;
  logic [IDX_W-1:0]  out_src_r;
  logic              out_tv_r;

  logic [IDX_W-1:0]  parent;
  logic [CH_W-1:0]   lch, rch;
  logic              l_ok, r_ok, pick_l, pick_r;
  ent_t              best;
  logic [IDX_W-1:0]  best_idx;

  // effective arity: 0 acts as 1, clamp at MAX_STREAMS
  always_comb begin
    arity = arity_cfg_r;
    if (arity_cfg_r == '0) arity = CNT_W'(1);
    else if (arity_cfg_r > CNT_W'(MAX_STREAMS)) arity = CNT_W'(MAX_STREAMS);
  end

  assign parent = (idx_r - IDX_W'(1)) >> 1;
  assign lch    = {1'b0, idx_r, 1'b0} + CH_W'(1);
  assign rch    = lch + CH_W'(1);
  assign l_ok   = lch < CH_W'(cnt_r);
  assign r_ok   = rch < CH_W'(cnt_r);

  // pick the smallest of moving entry and valid children
  always_comb begin
    best     = cur_r;
    best_idx = idx_r;
    pick_l   = l_ok && ent_before(rda_r, cur_r);
    if (pick_l) begin
      best     = rda_r;
      best_idx = lch[IDX_W-1:0];
    end
    pick_r = r_ok && ent_before(rdb_r, best);
    if (pick_r) begin
      best     = rdb_r;
      best_idx = rch[IDX_W-1:0];
    end
  end

  always_comb begin
    sts.cmd      = cmd_r;
    sts.ins_ok   = pres_r && (CNT_W'(cur_r.src) < arity) && (cnt_r < arity);
    sts.empty    = (cnt_r == '0);
    sts.at_root  = (idx_r == '0);
    sts.up_move  = ent_before(cur_r, rda_r);
    sts.dn_move  = pick_l || pick_r;
    sts.last_one = (cnt_r == CNT_W'(1));
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    cmd_nxt     = cmd_r;
    pres_nxt    = pres_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    res_src_nxt = res_src_r;
    res_tv_nxt  = res_tv_r;
    mem_we      = 1'b0;
    mem_wa      = idx_r;
    mem_wd      = cur_r;
    mem_ra      = '0;
    mem_rb      = '0;
    unique case (ctl.op)
      OP_CAPTURE: begin
        cur_nxt.key = in_value;
        cur_nxt.src = in_source;
        cmd_nxt     = in_cmd;
        pres_nxt    = in_present;
      end
      OP_CLEAR, OP_DONE, OP_REJECT: begin
        if (ctl.op != OP_REJECT) cnt_nxt = '0;
        res_st_nxt  = (ctl.op == OP_DONE) ? ST_DONE : ST_ACK;
        res_val_nxt = '0;
        res_src_nxt = '0;
        res_tv_nxt  = 1'b0;
      end
      OP_INSERT: begin
        idx_nxt     = cnt_r[IDX_W-1:0];
        cnt_nxt     = cnt_r + CNT_W'(1);
        res_st_nxt  = ST_ACK;
        res_val_nxt = '0;
        res_src_nxt = cur_r.src;
        res_tv_nxt  = 1'b1;
      end
      OP_PUT: mem_we = 1'b1;
      OP_UP_RD: mem_ra = parent;
      OP_UP_MV: begin
        mem_we  = 1'b1;
        mem_wd  = rda_r;
        idx_nxt = parent;
      end
      OP_EXT_RD: begin
        mem_ra = '0;
        mem_rb = IDX_W'(cnt_r - CNT_W'(1));
      end
      OP_EXTRACT: begin
        res_st_nxt  = ST_VALUE;
        res_val_nxt = rda_r.key;
        res_src_nxt = rda_r.src;
        res_tv_nxt  = 1'b1;
        cnt_nxt     = cnt_r - CNT_W'(1);
        cur_nxt     = rdb_r;
        idx_nxt     = '0;
      end
      OP_DN_RD: begin
        mem_ra = lch[IDX_W-1:0];
        mem_rb = rch[IDX_W-1:0];
      end
      OP_DN_MV: begin
        mem_we  = 1'b1;
        mem_wd  = best;
        idx_nxt = best_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rda_r <= mem[mem_ra];
    rdb_r <= mem[mem_rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      arity_cfg_r <= CNT_W'(MAX_STREAMS);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) arity_cfg_r <= cfg_wdata;
      if (ctl.op == OP_OUT_LD) out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cur_r     <= cur_nxt;
    cmd_r     <= cmd_nxt;
    pres_r    <= pres_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_src_r <= res_src_nxt;
    res_tv_r  <= res_tv_nxt;
    if (ctl.op == OP_OUT_LD) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_src_r <= res_src_r;
      out_tv_r  <= res_tv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_st_r;
  assign out_value        = out_val_r;
  assign out_taken_source = out_src_r;
  assign out_taken_valid  = out_tv_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_STREAMS))
    else $error("heap count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_OUT_LD) |-> !(out_valid_r && !out_ready))
    else $error("result register loaded while a word still waits");

  a_insert_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_INSERT) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow heap count");

  a_extract_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EXTRACT) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("extract did not shrink heap count");

endmodule

// ===== rtl/k_way_merge_heap.sv =====
// k_way_merge_heap: min-heap merge of up to 16 sorted signed streams.
// Per word: start, reject and take of an empty heap load the result directly; load and
// refill sift the new entry up one level per read/compare pair; take extracts the root
// and, unless it was the last entry, sifts the last entry down, up to 3 levels.
// One word in work at a time: a new word is taken only once the last result is loaded;
// a result waiting in the output register holds off the next word's result, and so the input.
// Reset (rst_n, synchronous): heap empty, arity 16, no result pending.
module k_way_merge_heap (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [kwmh_pkg::IDX_W-1:0]  in_source,
  input  logic signed [31:0]          in_value,
  input  logic                        in_present,
  // arity register write
  input  logic                        cfg_we,
  input  logic [kwmh_pkg::CNT_W-1:0]  cfg_wdata,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_value,
  output logic [kwmh_pkg::IDX_W-1:0]  out_taken_source,
  output logic                        out_taken_valid
);
  import kwmh_pkg::*;

  // controller issues one op a cycle; datapath reports flags back
  ctl_cmd_t ctl;
  dp_sts_t  sts;

  // Sequencer: captures a word, decodes the command, then walks the heap
  // one level per read/compare pair (sift up on insert, sift down on take).
  kwmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: 16-entry heap memory (one write, two registered reads),
  // moving-entry and index registers, fill count, arity and result register.
  kwmh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_source        (in_source),
    .in_value         (in_value),
    .in_present       (in_present),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_taken_source (out_taken_source),
    .out_taken_valid  (out_taken_valid)
  );

endmodule
